// ===== rtl/characteristic_polynomial_leverrier_core_defines.svh =====
// Assertion macros for the characteristic polynomial core.
// No dependencies; included by the top level before its module header.
`ifndef CHARACTERISTIC_POLYNOMIAL_LEVERRIER_CORE_DEFINES_SVH
`define CHARACTERISTIC_POLYNOMIAL_LEVERRIER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// property that must hold whenever its antecedent does, same cycle
`define CPL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("characteristic polynomial core: implication failed");
// property that must hold in the cycle after its antecedent
`define CPL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("characteristic polynomial core: next-cycle check failed");
`else
`define CPL_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define CPL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/cpl_pkg.sv =====
// Shared types, constants and saturating arithmetic for the
// characteristic polynomial core. No dependencies.
package cpl_pkg;

   localparam int ELEM_W  = 32;
   localparam int ACC_W   = 64;
   localparam int ORDER_W = 5;

   localparam logic signed [ACC_W-1:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic                    sat;
      logic signed [ACC_W-1:0] val;
   } sum_type;

   // add two Q32.32 values, clamp on overflow
   function automatic sum_type sadd(input logic signed [ACC_W-1:0] a,
                                    input logic signed [ACC_W-1:0] b);
      sum_type                 r;
      logic signed [ACC_W-1:0] s;
      s = a + b;
      r.sat = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
      if (r.sat) begin
         r.val = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
      end else begin
         r.val = s;
      end
      return r;
   endfunction

endpackage

// ===== rtl/characteristic_polynomial_leverrier_core.sv =====
// Top level of the Faddeev-LeVerrier characteristic polynomial core.
// Depends on cpl_pkg and characteristic_polynomial_leverrier_core_defines.svh.
//
// Usage:
//   Write the order n with csr_write_enable/csr_write_data while idle; 0 is taken
//   as 1, values above MAX_ORDER as MAX_ORDER. A write restarts loading.
//   Feed the n*n entries of A (signed Q16.16, row-major) one per cycle: an item
//   is taken on a clock edge with start high and busy low; busy stays low
//   until the last entry is taken.
//   After the last entry the core runs n iterations on its matrix memories.
//   Each multiply-accumulate walks the read, magnitude, low multiply, high
//   multiply, scale and accumulate states (ST_MRD to ST_MACC), forming the
//   product from 32x32 multiplies of |A| by the low and high halves of |S|.
//   Coefficients c[0]..c[n] then come out in turn on the rsp_
//   ports, each valid for the single cycle rsp_strobe is high; the receiver
//   cannot stall. rsp_last marks c[n], which also carries rsp_all_positive.
//   busy falls with the last result and the next matrix may be loaded.
//   Reset is synchronous: order 1, loading from the first entry, no result.
`include "characteristic_polynomial_leverrier_core_defines.svh"
module characteristic_polynomial_leverrier_core
   import cpl_pkg::*;
#(
   parameter int MAX_ORDER = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ELEM_W-1:0] req_matrix_element,
   output logic                     busy,
   input  logic                     csr_write_enable,
   input  logic [ORDER_W-1:0]       csr_write_data,
   output logic                     rsp_strobe,
   output logic [ORDER_W-1:0]       rsp_coeff_index,
   output logic signed [ACC_W-1:0]  rsp_coefficient,
   output logic                     rsp_overflow,
   output logic                     rsp_all_positive,
   output logic                     rsp_last
);

   localparam int CW    = $clog2(MAX_ORDER + 1);
   localparam int DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_LOAD, ST_INIT, ST_MRD, ST_MMAG, ST_MLO, ST_MHI, ST_MQ, ST_MACC,
      ST_TRACE, ST_DIV, ST_COEF, ST_URD, ST_UWR, ST_EMRD, ST_EMOUT
   } state_type;

   state_type state_ff;

   // memories
   logic        [ELEM_W-1:0] matrix_store_ff [DEPTH];
   logic signed [ACC_W-1:0]  accum_matrix_ff [DEPTH];
   logic signed [ACC_W-1:0]  product_matrix_ff [DEPTH];
   logic signed [ACC_W-1:0]  coeff_store_ff [MAX_ORDER+1];
   logic        [ELEM_W-1:0] mat_rd_ff;
   logic signed [ACC_W-1:0]  s_rd_ff, t_rd_ff, c_rd_ff;

   // control and datapath registers
   logic [CW-1:0]           order_ff, ld_row_ff, ld_col_ff;
   logic [CW-1:0]           i_ff, j_ff, m_ff, k_ff, e_ff;
   logic                    sat_ff, pos_ff, neg_ff, trneg_ff;
   logic [31:0]             ma_ff;
   logic [63:0]             ms_ff, lo_ff, hi_ff, dvd_ff;
   logic signed [ACC_W-1:0] prod_ff, acc_ff, tr_ff, c_ff;
   logic [4:0]              rem_ff;
   logic [5:0]              dcnt_ff;

   logic [CW-1:0] n_m1;
   logic [CW-1:0] order_in;
   logic          accept;
   logic          last_i, last_j, last_m;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
      return AW'(r) * AW'(MAX_ORDER) + AW'(c);
   endfunction

   assign busy   = (state_ff != ST_LOAD);
   assign accept = start && (state_ff == ST_LOAD);
   assign n_m1   = order_ff - CW'(1);
   assign last_i = (i_ff == n_m1);
   assign last_j = (j_ff == n_m1);
   assign last_m = (m_ff == n_m1);

   // clamp a written order into 1..MAX_ORDER
   always_comb begin
      if (csr_write_data == '0) begin
         order_in = CW'(1);
      end else if (csr_write_data > ORDER_W'(MAX_ORDER)) begin
         order_in = CW'(MAX_ORDER);
      end else begin
         order_in = CW'(csr_write_data);
      end
   end

   // product magnitude to Q32.32 with floor and saturation
   logic [63:0]             q_mag, q_rnd;
   logic signed [ACC_W-1:0] mq_prod;
   logic                    mq_sat;
   always_comb begin
      q_mag = {hi_ff[47:0], 16'h0000} + {16'h0000, lo_ff[63:16]};
      q_rnd = q_mag + 64'(neg_ff && (lo_ff[15:0] != 16'h0000));
      mq_sat  = 1'b0;
      mq_prod = '0;
      if (hi_ff[63:47] != '0) begin
         mq_sat  = 1'b1;
         mq_prod = neg_ff ? ACC_MIN : ACC_MAX;
      end else if (neg_ff) begin
         mq_sat  = (q_rnd > 64'h8000_0000_0000_0000);
         mq_prod = mq_sat ? ACC_MIN : -$signed(q_rnd);
      end else begin
         mq_sat  = q_mag[63];
         mq_prod = mq_sat ? ACC_MAX : $signed(q_mag);
      end
   end

   // saturating sums, divider step, coefficient sign fix
   sum_type     acc_sum, tr_sum, upd_sum;
   logic [5:0]  div_r2;
   logic        div_ge;
   logic [4:0]  div_rem;
   logic signed [ACC_W-1:0] coef_val;
   logic        coef_sat;
   always_comb begin
      acc_sum = sadd(acc_ff, prod_ff);
      tr_sum  = sadd(tr_ff, acc_ff);
      upd_sum = sadd(t_rd_ff, c_ff);
      div_r2  = {rem_ff, dvd_ff[63]};
      div_ge  = (div_r2 >= 6'(k_ff));
      div_rem = div_ge ? 5'(div_r2 - 6'(k_ff)) : div_r2[4:0];
      coef_sat = 1'b0;
      if (trneg_ff) begin
         coef_sat = dvd_ff[63];
         coef_val = coef_sat ? ACC_MAX : $signed(dvd_ff);
      end else begin
         coef_val = -$signed(dvd_ff);
      end
   end

   // memory ports
   logic            mat_we, s_we, t_we, c_we;
   logic [AW-1:0]   mat_waddr, mat_raddr, s_addr_w, s_raddr, t_addr;
   logic [CW-1:0]   c_waddr;
   logic signed [ACC_W-1:0] s_wdata, c_wdata;
   always_comb begin
      mat_we    = accept;
      mat_waddr = addr_of(ld_row_ff, ld_col_ff);
      mat_raddr = addr_of(i_ff, m_ff);
      s_raddr   = addr_of(m_ff, j_ff);
      s_addr_w  = addr_of(i_ff, j_ff);
      t_addr    = addr_of(i_ff, j_ff);
      s_we      = (state_ff == ST_INIT) || (state_ff == ST_UWR);
      if (state_ff == ST_INIT) begin
         s_wdata = (i_ff == j_ff) ? ONE_Q32 : '0;
      end else begin
         s_wdata = (i_ff == j_ff) ? upd_sum.val : t_rd_ff;
      end
      t_we    = (state_ff == ST_MACC) && last_m;
      c_we    = ((state_ff == ST_INIT) && last_i && last_j) || (state_ff == ST_COEF);
      c_waddr = (state_ff == ST_INIT) ? order_ff : order_ff - k_ff;
      c_wdata = (state_ff == ST_INIT) ? ONE_Q32 : coef_val;
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         matrix_store_ff[mat_waddr] <= req_matrix_element;
      end
      mat_rd_ff <= matrix_store_ff[mat_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         accum_matrix_ff[s_addr_w] <= s_wdata;
      end
      s_rd_ff <= accum_matrix_ff[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         product_matrix_ff[t_addr] <= acc_sum.val;
      end
      t_rd_ff <= product_matrix_ff[t_addr];
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         coeff_store_ff[c_waddr] <= c_wdata;
      end
      c_rd_ff <= coeff_store_ff[e_ff];
   end

   // sequencer: state, counters, datapath and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_LOAD;
         order_ff         <= CW'(1);
         ld_row_ff        <= '0;
         ld_col_ff        <= '0;
         sat_ff           <= 1'b0;
         rsp_strobe       <= 1'b0;
         rsp_last         <= 1'b0;
         rsp_all_positive <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         if (csr_write_enable) begin
            order_ff  <= order_in;
            ld_row_ff <= '0;
            ld_col_ff <= '0;
            sat_ff    <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  if (ld_col_ff == n_m1) begin
                     ld_col_ff <= '0;
                     if (ld_row_ff == n_m1) begin
                        ld_row_ff <= '0;
                        i_ff      <= '0;
                        j_ff      <= '0;
                        sat_ff    <= 1'b0;
                        pos_ff    <= 1'b1;
                        state_ff  <= ST_INIT;
                     end else begin
                        ld_row_ff <= ld_row_ff + CW'(1);
                     end
                  end else begin
                     ld_col_ff <= ld_col_ff + CW'(1);
                  end
               end
            end
            ST_INIT: begin
               // preset S to the identity
               if (last_j) begin
                  j_ff <= '0;
                  if (last_i) begin
                     i_ff     <= '0;
                     m_ff     <= '0;
                     k_ff     <= CW'(1);
                     acc_ff   <= '0;
                     tr_ff    <= '0;
                     state_ff <= ST_MRD;
                  end else begin
                     i_ff <= i_ff + CW'(1);
                  end
               end else begin
                  j_ff <= j_ff + CW'(1);
               end
            end
            ST_MRD: begin
               state_ff <= ST_MMAG;
            end
            ST_MMAG: begin
               neg_ff   <= mat_rd_ff[ELEM_W-1] ^ s_rd_ff[ACC_W-1];
               ma_ff    <= mat_rd_ff[ELEM_W-1] ? 32'(-mat_rd_ff) : mat_rd_ff;
               ms_ff    <= s_rd_ff[ACC_W-1] ? 64'(-s_rd_ff) : 64'(s_rd_ff);
               state_ff <= ST_MLO;
            end
            ST_MLO: begin
               lo_ff    <= 64'(ma_ff) * 64'(ms_ff[31:0]);
               state_ff <= ST_MHI;
            end
            ST_MHI: begin
               hi_ff    <= 64'(ma_ff) * 64'(ms_ff[63:32]);
               state_ff <= ST_MQ;
            end
            ST_MQ: begin
               prod_ff  <= mq_prod;
               sat_ff   <= sat_ff | mq_sat;
               state_ff <= ST_MACC;
            end
            ST_MACC, ST_TRACE: begin
               // accumulate, then fold diagonal entries into the trace
               if (state_ff == ST_MACC) begin
                  if (!last_m || (i_ff == j_ff)) begin
                     acc_ff <= acc_sum.val;
                  end
                  sat_ff <= sat_ff | acc_sum.sat;
               end else begin
                  tr_ff  <= tr_sum.val;
                  sat_ff <= sat_ff | tr_sum.sat;
               end
               if ((state_ff == ST_MACC) && !last_m) begin
                  m_ff     <= m_ff + CW'(1);
                  state_ff <= ST_MRD;
               end else if ((state_ff == ST_MACC) && (i_ff == j_ff)) begin
                  state_ff <= ST_TRACE;
               end else begin
                  m_ff   <= '0;
                  acc_ff <= '0;
                  if (last_j) begin
                     j_ff <= '0;
                     if (last_i) begin
                        i_ff     <= '0;
                        trneg_ff <= (state_ff == ST_TRACE) ? tr_sum.val[ACC_W-1]
                                                           : tr_ff[ACC_W-1];
                        dvd_ff   <= (state_ff == ST_TRACE) ?
                                    (tr_sum.val[ACC_W-1] ? 64'(-tr_sum.val)
                                                         : 64'(tr_sum.val)) :
                                    (tr_ff[ACC_W-1] ? 64'(-tr_ff) : 64'(tr_ff));
                        rem_ff   <= '0;
                        dcnt_ff  <= '0;
                        state_ff <= ST_DIV;
                     end else begin
                        i_ff     <= i_ff + CW'(1);
                        state_ff <= ST_MRD;
                     end
                  end else begin
                     j_ff     <= j_ff + CW'(1);
                     state_ff <= ST_MRD;
                  end
               end
            end
            ST_DIV: begin
               // restoring division of |trace| by k, one bit a cycle
               rem_ff  <= div_rem;
               dvd_ff  <= {dvd_ff[62:0], div_ge};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd63) begin
                  state_ff <= ST_COEF;
               end
            end
            ST_COEF: begin
               c_ff     <= coef_val;
               sat_ff   <= sat_ff | coef_sat;
               pos_ff   <= pos_ff & !coef_val[ACC_W-1] & (coef_val != '0);
               i_ff     <= '0;
               j_ff     <= '0;
               state_ff <= ST_URD;
            end
            ST_URD: begin
               state_ff <= ST_UWR;
            end
            ST_UWR: begin
               // S = T + c on the diagonal
               if (i_ff == j_ff) begin
                  sat_ff <= sat_ff | upd_sum.sat;
               end
               state_ff <= ST_URD;
               if (last_j) begin
                  j_ff <= '0;
                  if (last_i) begin
                     i_ff   <= '0;
                     tr_ff  <= '0;
                     acc_ff <= '0;
                     m_ff   <= '0;
                     if (k_ff == order_ff) begin
                        e_ff     <= '0;
                        state_ff <= ST_EMRD;
                     end else begin
                        k_ff     <= k_ff + CW'(1);
                        state_ff <= ST_MRD;
                     end
                  end else begin
                     i_ff <= i_ff + CW'(1);
                  end
               end else begin
                  j_ff <= j_ff + CW'(1);
               end
            end
            ST_EMRD: begin
               state_ff <= ST_EMOUT;
            end
            ST_EMOUT: begin
               // drive one item, then read the next in ST_EMRD until c[n]
               rsp_strobe       <= 1'b1;
               rsp_coeff_index  <= ORDER_W'(e_ff);
               rsp_coefficient  <= c_rd_ff;
               rsp_overflow     <= sat_ff;
               rsp_last         <= (e_ff == order_ff);
               rsp_all_positive <= (e_ff == order_ff) && pos_ff;
               if (e_ff == order_ff) begin
                  state_ff <= ST_LOAD;
               end else begin
                  e_ff     <= e_ff + CW'(1);
                  state_ff <= ST_EMRD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   `CPL_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe, !rsp_strobe)
   `CPL_ASSERT_IMPLIES(a_last_index, clock, reset, rsp_strobe && rsp_last, rsp_coeff_index == ORDER_W'(order_ff))
   `CPL_ASSERT_IMPLIES(a_pos_on_last, clock, reset, rsp_all_positive, rsp_last)
   `CPL_ASSERT_IMPLIES(a_no_load_busy, clock, reset, mat_we, !busy)

endmodule
